// ----- design/lpdm_pkg.sv -----
`default_nettype none

package lpdm_pkg;

	// Directory geometry
	localparam int NUM_ENTRIES = 1024;
	localparam int PAGE_SHIFT  = 22;
	localparam int IDX_W       = $clog2(NUM_ENTRIES);
	localparam int SLOT_W      = 10;
	localparam int CNT_W       = 11;
	localparam int ADDR_W      = 32;
	localparam int FLAG_W      = 8;

	// Present bitmap: one bit per entry, 32 entries per word
	localparam int BMP_W      = 32;
	localparam int BIT_W      = 5;
	localparam int BMP_WORDS  = (NUM_ENTRIES + BMP_W - 1) / BMP_W;
	localparam int WORD_AW    = (BMP_WORDS > 1) ? $clog2(BMP_WORDS) : 1;

	// Stream payload widths
	localparam int S_DATA_W = 88;
	localparam int M_DATA_W = 88;

	// Entry flag bits
	localparam logic [ADDR_W-1:0] ENTRY_PRESENT = 32'h0000_0001;
	localparam logic [ADDR_W-1:0] ENTRY_WRITE   = 32'h0000_0002;
	localparam logic [ADDR_W-1:0] ENTRY_LARGE   = 32'h0000_0080;

	typedef enum logic [1:0] {
		MODE_MAP       = 2'd0,
		MODE_UNMAP     = 2'd1,
		MODE_TRANSLATE = 2'd2,
		MODE_FIND      = 2'd3
	} mode_t;

	typedef enum logic [2:0] {
		STS_OK         = 3'd0,
		STS_VIRT_BAD   = 3'd1,
		STS_PHYS_BAD   = 3'd2,
		STS_MAPPED     = 3'd3,
		STS_NOT_MAPPED = 3'd4,
		STS_NONE_FREE  = 3'd5
	} status_t;

	// Result of one bitmap word scan
	typedef struct packed {
		logic             found;
		logic [BIT_W-1:0] pos;
	} scan_res_t;

endpackage

`default_nettype wire

// ----- design/lpdm_ram.sv -----
`default_nettype none

module lpdm_ram #(
	parameter int WIDTH  = 32,
	parameter int DEPTH  = 1024,
	parameter int ADDR_W = 10
) (
	input  wire logic              clk,
	input  wire logic              we,
	input  wire logic [ADDR_W-1:0] waddr,
	input  wire logic [WIDTH-1:0]  wdata,
	input  wire logic [ADDR_W-1:0] raddr,
	output logic      [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

// ----- design/lpdm_free_scan.sv -----
`default_nettype none

module lpdm_free_scan
	import lpdm_pkg::*;
(
	input  wire logic [BMP_W-1:0] word,
	input  wire logic [BIT_W-1:0] word_idx,
	input  wire logic [BIT_W-1:0] lo_bit,
	input  wire logic             first,
	output scan_res_t             res
);

	logic [BMP_W-1:0] free_bits;
	logic [BMP_W-1:0] lowest;
	logic [BIT_W-1:0] pos;

	// Mark free bits that lie at or above the bound and inside the directory
	always_comb begin
		for (int i = 0; i < BMP_W; i++) begin
			free_bits[i] = !word[i]
				&& (!first || (BIT_W'(i) >= lo_bit))
				&& (CNT_W'({word_idx, BIT_W'(i)}) < CNT_W'(NUM_ENTRIES));
		end
	end

	// Isolate the lowest free bit and encode its position
	assign lowest = free_bits & (~free_bits + BMP_W'(1));

	always_comb begin
		pos = '0;
		for (int i = 0; i < BMP_W; i++) begin
			if (lowest[i]) begin
				pos = pos | BIT_W'(i);
			end
		end
	end

	assign res.found = |free_bits;
	assign res.pos   = pos;

endmodule

`default_nettype wire

// ----- design/large_page_directory_manager.sv -----
`default_nettype none

// Channel  Dir  Handshake          Payload (lowest bit first)
// s_axis   in   s_tvalid/s_tready  mode, virt_addr, phys_addr, extra_flags, search_start
// m_axis   out  m_tvalid/m_tready  status, frame_addr, entry_word, free_slot, free_total
//
// After reset a clearing pass zeroes the present bitmap, one word a cycle:
// over all BMP_WORDS words (32 at 1024 entries); no request is taken meanwhile.
// Map, unmap and translate pass through accept, bitmap/entry read and result;
// a rejected address goes from accept straight to result. Find free scans one
// bitmap word a cycle (1 to BMP_WORDS) with the single word-scan unit, then result.
// A new request is taken while the previous result still waits in the
// output register; the sequencer stalls in its result state until it drains.

module large_page_directory_manager
	import lpdm_pkg::*;
(
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                s_tvalid,
	output logic                     s_tready,
	// mode[1:0], virt_addr[33:2], phys_addr[65:34], extra_flags[73:66],
	// search_start[83:74], zero pad[87:84]
	input  wire logic [S_DATA_W-1:0] s_tdata,
	output logic                     m_tvalid,
	input  wire logic                m_tready,
	// status[2:0], frame_addr[34:3], entry_word[66:35], free_slot[76:67],
	// free_total[87:77]
	output logic      [M_DATA_W-1:0] m_tdata
);

	typedef enum logic [4:0] {
		ST_CLEAR = 5'b00001,
		ST_IDLE  = 5'b00010,
		ST_LOOK  = 5'b00100,
		ST_SCAN  = 5'b01000,
		ST_DONE  = 5'b10000
	} state_t;

	state_t               state_q;
	logic [WORD_AW-1:0]   clr_q;
	logic [CNT_W-1:0]     free_q;
	logic                 m_tvalid_q;
	logic [M_DATA_W-1:0]  m_tdata_q;

	mode_t                mode_q;
	logic [SLOT_W-1:0]    slot_q;
	logic [ADDR_W-1:0]    pa_q;
	logic [FLAG_W-1:0]    flags_q;
	logic [WORD_AW-1:0]   word_q;
	logic                 first_q;

	status_t              res_status_q;
	logic [ADDR_W-1:0]    res_frame_q;
	logic [ADDR_W-1:0]    res_entry_q;
	logic [SLOT_W-1:0]    res_slot_q;

	mode_t                in_mode;
	logic [ADDR_W-1:0]    in_virt;
	logic [ADDR_W-1:0]    in_phys;
	logic [FLAG_W-1:0]    in_flags;
	logic [SLOT_W-1:0]    in_start;

	logic                 acc;
	logic                 out_load;
	logic                 virt_bad;
	logic                 phys_bad;
	logic                 acc_err;
	status_t              acc_status;

	logic                 bmp_we;
	logic [WORD_AW-1:0]   bmp_waddr;
	logic [BMP_W-1:0]     bmp_wdata;
	logic [WORD_AW-1:0]   bmp_raddr;
	logic [BMP_W-1:0]     bmp_rdata;
	logic                 dir_we;
	logic [ADDR_W-1:0]    dir_wdata;
	logic [ADDR_W-1:0]    dir_rdata;

	logic                 present;
	logic [BMP_W-1:0]     bit_mask;
	logic                 last_word;
	scan_res_t            scan;

	// Unpack the request
	assign in_mode  = mode_t'(s_tdata[1:0]);
	assign in_virt  = s_tdata[33:2];
	assign in_phys  = s_tdata[65:34];
	assign in_flags = s_tdata[73:66];
	assign in_start = s_tdata[83:74];

	assign s_tready = (state_q == ST_IDLE);
	assign acc      = s_tvalid && s_tready;
	assign out_load = (state_q == ST_DONE) && (!m_tvalid_q || m_tready);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	// Check alignment and range at accept time
	assign phys_bad = |in_phys[PAGE_SHIFT-1:0];
	assign virt_bad = (|in_virt[PAGE_SHIFT-1:0])
		|| (CNT_W'(in_virt[PAGE_SHIFT +: SLOT_W]) >= CNT_W'(NUM_ENTRIES));

	always_comb begin
		acc_err    = 1'b0;
		acc_status = STS_OK;
		case (in_mode)
			MODE_MAP: begin
				if (phys_bad) begin
					acc_err    = 1'b1;
					acc_status = STS_PHYS_BAD;
				end else if (virt_bad) begin
					acc_err    = 1'b1;
					acc_status = STS_VIRT_BAD;
				end
			end
			MODE_UNMAP, MODE_TRANSLATE: begin
				if (virt_bad) begin
					acc_err    = 1'b1;
					acc_status = STS_VIRT_BAD;
				end
			end
			MODE_FIND: begin
				if (CNT_W'(in_start) >= CNT_W'(NUM_ENTRIES)) begin
					acc_err    = 1'b1;
					acc_status = STS_NONE_FREE;
				end
			end
			default: begin
				acc_err    = 1'b1;
				acc_status = STS_VIRT_BAD;
			end
		endcase
	end

	// Present bit of the addressed entry
	assign bit_mask  = BMP_W'(1) << slot_q[BIT_W-1:0];
	assign present   = |(bmp_rdata & bit_mask);
	assign last_word = (word_q == WORD_AW'(BMP_WORDS - 1));

	// Steer the bitmap read port: next scan word, or the word of the request
	always_comb begin
		if (state_q == ST_SCAN) begin
			bmp_raddr = word_q + WORD_AW'(1);
		end else if (in_mode == MODE_FIND) begin
			bmp_raddr = in_start[BIT_W +: WORD_AW];
		end else begin
			bmp_raddr = in_virt[PAGE_SHIFT + BIT_W +: WORD_AW];
		end
	end

	// Steer bitmap writes: clearing pass, then map/unmap updates
	always_comb begin
		bmp_we    = 1'b0;
		bmp_waddr = slot_q[BIT_W +: WORD_AW];
		bmp_wdata = bmp_rdata;
		if (state_q == ST_CLEAR) begin
			bmp_we    = 1'b1;
			bmp_waddr = clr_q;
			bmp_wdata = '0;
		end else if (state_q == ST_LOOK) begin
			if (mode_q == MODE_MAP && !present) begin
				bmp_we    = 1'b1;
				bmp_wdata = bmp_rdata | bit_mask;
			end else if (mode_q == MODE_UNMAP && present) begin
				bmp_we    = 1'b1;
				bmp_wdata = bmp_rdata & ~bit_mask;
			end
		end
	end

	assign dir_we    = (state_q == ST_LOOK) && (mode_q == MODE_MAP) && !present;
	assign dir_wdata = pa_q | ENTRY_PRESENT | ENTRY_WRITE | ENTRY_LARGE
		| ADDR_W'(flags_q);

	lpdm_ram #(
		.WIDTH  (BMP_W),
		.DEPTH  (BMP_WORDS),
		.ADDR_W (WORD_AW)
	) u_bitmap (
		.clk   (clk),
		.we    (bmp_we),
		.waddr (bmp_waddr),
		.wdata (bmp_wdata),
		.raddr (bmp_raddr),
		.rdata (bmp_rdata)
	);

	lpdm_ram #(
		.WIDTH  (ADDR_W),
		.DEPTH  (NUM_ENTRIES),
		.ADDR_W (IDX_W)
	) u_dir (
		.clk   (clk),
		.we    (dir_we),
		.waddr (slot_q[IDX_W-1:0]),
		.wdata (dir_wdata),
		.raddr (in_virt[PAGE_SHIFT +: IDX_W]),
		.rdata (dir_rdata)
	);

	lpdm_free_scan u_scan (
		.word     (bmp_rdata),
		.word_idx (BIT_W'(word_q)),
		.lo_bit   (slot_q[BIT_W-1:0]),
		.first    (first_q),
		.res      (scan)
	);

	// Sequencer, free count and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_CLEAR;
			clr_q      <= '0;
			free_q     <= CNT_W'(NUM_ENTRIES);
			m_tvalid_q <= 1'b0;
		end else begin
			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + WORD_AW'(1);
					if (clr_q == WORD_AW'(BMP_WORDS - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (acc) begin
						if (acc_err) begin
							state_q <= ST_DONE;
						end else if (in_mode == MODE_FIND) begin
							state_q <= ST_SCAN;
						end else begin
							state_q <= ST_LOOK;
						end
					end
				end
				ST_LOOK: begin
					if (mode_q == MODE_MAP && !present && free_q != '0) begin
						free_q <= free_q - CNT_W'(1);
					end else if (mode_q == MODE_UNMAP && present
							&& free_q < CNT_W'(NUM_ENTRIES)) begin
						free_q <= free_q + CNT_W'(1);
					end
					state_q <= ST_DONE;
				end
				ST_SCAN: begin
					if (scan.found || last_word) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase

			if (out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	// Request latches and result fields
	always_ff @(posedge clk) begin
		if (acc) begin
			mode_q       <= in_mode;
			slot_q       <= (in_mode == MODE_FIND) ? in_start : in_virt[PAGE_SHIFT +: SLOT_W];
			pa_q         <= in_phys;
			flags_q      <= in_flags;
			word_q       <= bmp_raddr;
			first_q      <= 1'b1;
			res_status_q <= acc_status;
			res_frame_q  <= '0;
			res_entry_q  <= '0;
			res_slot_q   <= '0;
		end

		if (state_q == ST_LOOK) begin
			case (mode_q)
				MODE_MAP: res_status_q <= present ? STS_MAPPED : STS_OK;
				MODE_UNMAP: res_status_q <= present ? STS_OK : STS_NOT_MAPPED;
				MODE_TRANSLATE: begin
					if (present) begin
						res_status_q <= STS_OK;
						res_entry_q  <= dir_rdata;
						res_frame_q  <= {dir_rdata[ADDR_W-1:PAGE_SHIFT], PAGE_SHIFT'(0)};
					end else begin
						res_status_q <= STS_NOT_MAPPED;
					end
				end
				default: res_status_q <= STS_NONE_FREE;
			endcase
		end

		// Advance the scan one bitmap word a cycle
		if (state_q == ST_SCAN) begin
			if (scan.found) begin
				res_status_q <= STS_OK;
				res_slot_q   <= SLOT_W'({BIT_W'(word_q), scan.pos});
			end else if (last_word) begin
				res_status_q <= STS_NONE_FREE;
			end else begin
				word_q  <= word_q + WORD_AW'(1);
				first_q <= 1'b0;
			end
		end

		if (out_load) begin
			m_tdata_q <= {free_q, res_slot_q, res_entry_q, res_frame_q, res_status_q};
		end
	end

	// Free count stays within the directory size
	a_free_range: assert property (@(posedge clk) disable iff (!arst_n)
		free_q <= CNT_W'(NUM_ENTRIES))
		else $error("free count above directory size");

	// One request at a time: no accept right after an accept
	a_one_inflight: assert property (@(posedge clk) disable iff (!arst_n)
		acc |=> !s_tready)
		else $error("request accepted while another is in progress");

	// A result appears only when the sequencer hands it over
	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(state_q == ST_DONE))
		else $error("result valid raised outside the result state");

	// Find free never reports a slot outside the directory
	a_slot_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |-> (CNT_W'(res_slot_q) < CNT_W'(NUM_ENTRIES)))
		else $error("free slot beyond directory");

endmodule

`default_nettype wire

// ----- tb/large_page_directory_manager_checker.sv -----
module large_page_directory_manager_checker
	import lpdm_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	input  logic                s_tready,
	input  logic [S_DATA_W-1:0] s_tdata,
	input  logic                m_tvalid,
	input  logic                m_tready,
	input  logic [M_DATA_W-1:0] m_tdata,
	output int                  fault_count,
	output int                  replies_pending,
	output int                  replies_checked
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		mode_t             mode;
		logic [ADDR_W-1:0] virt_addr;
		logic [ADDR_W-1:0] phys_addr;
		logic [FLAG_W-1:0] extra_flags;
		logic [SLOT_W-1:0] search_start;
	} dir_request_t;

	typedef struct packed {
		status_t           status;
		logic [ADDR_W-1:0] frame_addr;
		logic [ADDR_W-1:0] entry_word;
		logic [SLOT_W-1:0] free_slot;
		logic [CNT_W-1:0]  free_total;
	} dir_reply_t;

	// Shadow copy of the directory and its free counter
	logic [ADDR_W-1:0] page_dir [NUM_ENTRIES];
	logic [CNT_W-1:0]  free_entries;
	dir_reply_t        reply_q [$];

	// Aligned to a 4 MB page and inside the directory
	function automatic logic slot_valid(input logic [ADDR_W-1:0] va);
		return (va[PAGE_SHIFT-1:0] == '0) && ((va >> PAGE_SHIFT) < NUM_ENTRIES);
	endfunction

	// Apply one request to the shadow directory and build its reply
	task automatic apply_request(input dir_request_t rq, output dir_reply_t rp);
		logic [SLOT_W-1:0] slot;
		logic              hit;
		int                i;
		rp = '0;
		rp.status = STS_OK;
		slot = rq.virt_addr[PAGE_SHIFT +: SLOT_W];
		case (rq.mode)
			MODE_MAP: begin
				if (rq.phys_addr[PAGE_SHIFT-1:0] != '0) begin
					rp.status = STS_PHYS_BAD;
				end else if (!slot_valid(rq.virt_addr)) begin
					rp.status = STS_VIRT_BAD;
				end else if (page_dir[slot][0]) begin
					rp.status = STS_MAPPED;
				end else begin
					page_dir[slot] = rq.phys_addr | ENTRY_PRESENT | ENTRY_WRITE | ENTRY_LARGE
						| {{(ADDR_W-FLAG_W){1'b0}}, rq.extra_flags};
					if (free_entries != '0)
						free_entries = free_entries - CNT_W'(1);
				end
			end
			MODE_UNMAP: begin
				if (!slot_valid(rq.virt_addr)) begin
					rp.status = STS_VIRT_BAD;
				end else if (!page_dir[slot][0]) begin
					rp.status = STS_NOT_MAPPED;
				end else begin
					page_dir[slot] = '0;
					if (free_entries < CNT_W'(NUM_ENTRIES))
						free_entries = free_entries + CNT_W'(1);
				end
			end
			MODE_TRANSLATE: begin
				if (!slot_valid(rq.virt_addr)) begin
					rp.status = STS_VIRT_BAD;
				end else if (!page_dir[slot][0]) begin
					rp.status = STS_NOT_MAPPED;
				end else begin
					rp.entry_word = page_dir[slot];
					rp.frame_addr = {page_dir[slot][ADDR_W-1:PAGE_SHIFT], {PAGE_SHIFT{1'b0}}};
				end
			end
			default: begin
				// Scan upward from the lower bound for a clear present bit
				rp.status = STS_NONE_FREE;
				hit = 1'b0;
				for (i = int'(rq.search_start); i < NUM_ENTRIES && !hit; i++) begin
					if (!page_dir[i][0]) begin
						hit = 1'b1;
						rp.status = STS_OK;
						rp.free_slot = i[SLOT_W-1:0];
					end
				end
			end
		endcase
		rp.free_total = free_entries;
	endtask

	// Predict on every request transaction, compare on every reply transaction
	always @(posedge clk or negedge arst_n) begin : watch
		dir_request_t rq;
		dir_reply_t   want;
		dir_reply_t   got;
		if (!arst_n) begin
			for (int k = 0; k < NUM_ENTRIES; k++)
				page_dir[k] = '0;
			free_entries = CNT_W'(NUM_ENTRIES);
			reply_q.delete();
			fault_count = 0;
			replies_pending = 0;
			replies_checked = 0;
		end else begin
			if (s_tvalid && s_tready) begin
				rq.mode         = mode_t'(s_tdata[1:0]);
				rq.virt_addr    = s_tdata[33:2];
				rq.phys_addr    = s_tdata[65:34];
				rq.extra_flags  = s_tdata[73:66];
				rq.search_start = s_tdata[83:74];
				apply_request(rq, want);
				reply_q.push_back(want);
			end
			if (m_tvalid && m_tready) begin
				got.status     = status_t'(m_tdata[2:0]);
				got.frame_addr = m_tdata[34:3];
				got.entry_word = m_tdata[66:35];
				got.free_slot  = m_tdata[76:67];
				got.free_total = m_tdata[87:77];
				replies_checked++;
				if (reply_q.size() == 0) begin
					if (fault_count < 10)
						$display("[%0t] reply with none outstanding: status=%0d data=%h",
							$realtime, got.status, m_tdata);
					fault_count++;
				end else begin
					want = reply_q.pop_front();
					if (got.status !== want.status || got.frame_addr !== want.frame_addr
						|| got.entry_word !== want.entry_word
						|| got.free_slot !== want.free_slot
						|| got.free_total !== want.free_total) begin
						if (fault_count < 10) begin
							$display("[%0t] expected st=%0d frame=%h entry=%h slot=%0d free=%0d",
								$realtime, want.status, want.frame_addr, want.entry_word,
								want.free_slot, want.free_total);
							$display("[%0t] actual   st=%0d frame=%h entry=%h slot=%0d free=%0d",
								$realtime, got.status, got.frame_addr, got.entry_word,
								got.free_slot, got.free_total);
						end
						fault_count++;
					end
				end
			end
			replies_pending = reply_q.size();
		end
	end

endmodule

// ----- tb/large_page_directory_manager_tb.sv -----
module large_page_directory_manager_tb;
	import lpdm_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int STALL_LIMIT = 2000;
	localparam int HOLD_CYCLES = 300;
	localparam int DRAIN_CYCLES = 64;
	localparam int SWEEP_FIRST = 640;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                s_tvalid = 1'b0;
	logic                s_tready;
	logic [S_DATA_W-1:0] s_tdata = '0;
	logic                m_tvalid;
	logic                m_tready = 1'b0;
	logic [M_DATA_W-1:0] m_tdata;

	int fault_count;
	int replies_pending;
	int replies_checked;
	int quiet_cycles = 0;
	int mode_sent [4];
	bit calm = 1'b0;
	bit hold_req = 1'b0;

	large_page_directory_manager uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	large_page_directory_manager_checker chk (
		.clk             (clk),
		.arst_n          (arst_n),
		.s_tvalid        (s_tvalid),
		.s_tready        (s_tready),
		.s_tdata         (s_tdata),
		.m_tvalid        (m_tvalid),
		.m_tready        (m_tready),
		.m_tdata         (m_tdata),
		.fault_count     (fault_count),
		.replies_pending (replies_pending),
		.replies_checked (replies_checked)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// End the run when no transaction moves for too long
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles == STALL_LIMIT) begin
				$display("watchdog: no transaction for %0d cycles", STALL_LIMIT);
				$display("CHECK FAILED");
				$finish;
			end
		end
	end

	// Reply side: random stalls, one long hold-off on request
	initial begin
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (hold_req) begin
				hold_req = 1'b0;
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else if (!calm && $urandom_range(0, 2) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 7)) @(posedge clk);
			end else begin
				m_tready <= 1'b1;
				repeat ($urandom_range(1, 12)) @(posedge clk);
			end
		end
	end

	// Offer one request and hold it until the transaction completes
	task automatic send_request(input mode_t md, input logic [ADDR_W-1:0] va,
		input logic [ADDR_W-1:0] pa, input logic [FLAG_W-1:0] fl,
		input logic [SLOT_W-1:0] st);
		bit took;
		if (!calm && $urandom_range(0, 5) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 7)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {4'b0000, st, fl, pa, va, md};
		mode_sent[int'(md)]++;
		do begin
			@(negedge clk);
			took = s_tready;
			@(posedge clk);
		end while (!took);
	endtask

	// Stop offering until every reply has come back
	task automatic wait_drained();
		s_tvalid <= 1'b0;
		do
			@(negedge clk);
		while (replies_pending != 0);
		@(posedge clk);
	endtask

	// Mostly well-formed requests on hot slots, some broken, some pure noise
	task automatic run_mix(input int count, input int upper_lo);
		int                k;
		int                pick;
		int                bit_no;
		logic [SLOT_W-1:0] slot;
		logic [SLOT_W-1:0] frame_no;
		logic [SLOT_W-1:0] st;
		logic [ADDR_W-1:0] va;
		logic [ADDR_W-1:0] pa;
		mode_t             md;
		for (k = 0; k < count; k++) begin
			pick = $urandom_range(0, 99);
			if (pick < 10) begin
				send_request(mode_t'($urandom_range(0, 3)), $urandom, $urandom,
					FLAG_W'($urandom), SLOT_W'($urandom));
			end else begin
				case ($urandom_range(0, 9))
					0, 1, 2, 3: slot = SLOT_W'($urandom_range(0, 63));
					4, 5, 6:    slot = SLOT_W'($urandom_range(upper_lo, NUM_ENTRIES - 1));
					default:    slot = SLOT_W'($urandom_range(0, NUM_ENTRIES - 1));
				endcase
				frame_no = SLOT_W'($urandom_range(0, 1023));
				va = {slot, {PAGE_SHIFT{1'b0}}};
				pa = {frame_no, {PAGE_SHIFT{1'b0}}};
				bit_no = $urandom_range(0, PAGE_SHIFT - 1);
				// Break one alignment now and then
				if (pick < 16)
					va[bit_no] = 1'b1;
				else if (pick < 20)
					pa[bit_no] = 1'b1;
				st = SLOT_W'($urandom_range(0, 1023));
				if ($urandom_range(0, 1) == 0)
					st = slot;
				pick = $urandom_range(0, 19);
				if (pick < 7)
					md = MODE_MAP;
				else if (pick < 12)
					md = MODE_UNMAP;
				else if (pick < 17)
					md = MODE_TRANSLATE;
				else
					md = MODE_FIND;
				send_request(md, va, pa, FLAG_W'($urandom), st);
			end
		end
	endtask

	// Fill the upper directory in order, probing it with finds along the way
	task automatic run_sweep(input int first);
		int                s;
		logic [SLOT_W-1:0] slot;
		logic [SLOT_W-1:0] frame_no;
		logic [SLOT_W-1:0] st;
		for (s = first; s < NUM_ENTRIES; s++) begin
			slot = s[SLOT_W-1:0];
			frame_no = SLOT_W'($urandom_range(0, 1023));
			send_request(MODE_MAP, {slot, {PAGE_SHIFT{1'b0}}},
				{frame_no, {PAGE_SHIFT{1'b0}}}, FLAG_W'($urandom), SLOT_W'($urandom));
			if ($urandom_range(0, 5) == 0) begin
				st = SLOT_W'($urandom_range(first, NUM_ENTRIES - 1));
				send_request(MODE_FIND, $urandom, $urandom, FLAG_W'($urandom), st);
			end
		end
		repeat (12) begin
			st = SLOT_W'($urandom_range(first, NUM_ENTRIES - 1));
			send_request(MODE_FIND, $urandom, $urandom, FLAG_W'($urandom), st);
		end
	endtask

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Empty directory: finds at both ends, misses on free entries
		send_request(MODE_FIND, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF, 10'd0);
		send_request(MODE_FIND, 32'h0, 32'h0, 8'h00, 10'd1023);
		send_request(MODE_TRANSLATE, 32'h0, 32'hFFFF_FFFF, 8'hFF, 10'h3FF);
		send_request(MODE_UNMAP, 32'hFFC0_0000, 32'h0, 8'h00, 10'd0);

		// Map checks: phys alignment first, then virt, then a present entry
		send_request(MODE_MAP, 32'h0000_0001, 32'h0000_0001, 8'h00, 10'd0);
		send_request(MODE_MAP, 32'h0020_0000, 32'hFFC0_0000, 8'h00, 10'd0);
		send_request(MODE_MAP, 32'h0, 32'h003F_FFFF, 8'h00, 10'd0);
		send_request(MODE_MAP, 32'h0, 32'hFFC0_0000, 8'hFF, 10'h3FF);
		send_request(MODE_MAP, 32'hFFC0_0000, 32'h0, 8'h00, 10'd0);
		send_request(MODE_MAP, 32'h0, 32'h0040_0000, 8'h00, 10'd0);
		send_request(MODE_MAP, 32'h8000_0000, 32'h5540_0000, 8'h5A, 10'd0);

		// Translate hits and address errors
		send_request(MODE_TRANSLATE, 32'h0, 32'h0, 8'h00, 10'd0);
		send_request(MODE_TRANSLATE, 32'hFFC0_0000, 32'h0, 8'h00, 10'd0);
		send_request(MODE_TRANSLATE, 32'h0040_0001, 32'h0, 8'h00, 10'd0);
		send_request(MODE_UNMAP, 32'h8000_0001, 32'h0, 8'h00, 10'd0);

		// Find around mapped slots, including nothing free above the bound
		send_request(MODE_FIND, 32'h0, 32'h0, 8'h00, 10'd0);
		send_request(MODE_FIND, 32'h0, 32'h0, 8'h00, 10'd1023);
		send_request(MODE_FIND, 32'h0, 32'h0, 8'h00, 10'd512);

		// Unmap, miss, and reuse a slot
		send_request(MODE_UNMAP, 32'h0, 32'hFFFF_FFFF, 8'hFF, 10'h3FF);
		send_request(MODE_TRANSLATE, 32'h0, 32'h0, 8'h00, 10'd0);
		send_request(MODE_FIND, 32'h0, 32'h0, 8'h00, 10'd0);
		send_request(MODE_UNMAP, 32'h0, 32'h0, 8'h00, 10'd0);
		send_request(MODE_MAP, 32'h0, 32'h0, 8'h00, 10'd0);
		send_request(MODE_UNMAP, 32'hFFC0_0000, 32'h0, 8'h00, 10'd0);
		send_request(MODE_FIND, 32'h0, 32'h0, 8'h00, 10'd1023);
		wait_drained();

		run_mix(120, 960);
		wait_drained();

		// Hold off replies while the sweep keeps offering requests
		hold_req = 1'b1;
		run_sweep(SWEEP_FIRST);
		wait_drained();

		run_mix(60, SWEEP_FIRST);
		calm = 1'b1;
		run_mix(60, SWEEP_FIRST);

		// Let the last replies drain
		s_tvalid <= 1'b0;
		do
			@(negedge clk);
		while (replies_pending != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		@(negedge clk);

		$display("Covered %0d requests: map %0d, unmap %0d, translate %0d, find %0d",
			mode_sent[0] + mode_sent[1] + mode_sent[2] + mode_sent[3],
			mode_sent[0], mode_sent[1], mode_sent[2], mode_sent[3]);
		$display("Checked %0d replies; slots %0d-%0d filled in order, %0d-cycle hold-off",
			replies_checked, SWEEP_FIRST, NUM_ENTRIES - 1, HOLD_CYCLES);
		if (fault_count == 0 && replies_pending == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
